/* hdl/bsst_pkg.sv */
package bsst_pkg;

	localparam int VAL_W = 32;
	localparam int CAP_W = 7;
	localparam int CNT_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam logic [VAL_W-1:0] GAP_INIT = '1;

	typedef struct packed {
		logic signed [VAL_W-1:0] new_value;
		logic start_new;
	} item_t;

	typedef struct packed {
		logic status;
		logic [CNT_W-1:0] held_count;
		logic spans_valid;
		logic [VAL_W-1:0] shortest_span;
		logic [VAL_W-1:0] longest_span;
	} result_t;

endpackage

/* hdl/bsst_in_if.sv */
interface bsst_in_if import bsst_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] new_value;
	logic start_new;

	modport source (output valid, output new_value, output start_new, input ready);
	modport sink (input valid, input new_value, input start_new, output ready);
endinterface

/* hdl/bsst_out_if.sv */
interface bsst_out_if import bsst_pkg::*; ();
	logic valid;
	logic ready;
	logic status;
	logic [CNT_W-1:0] held_count;
	logic spans_valid;
	logic [VAL_W-1:0] shortest_span;
	logic [VAL_W-1:0] longest_span;

	modport source (
		output valid, output status, output held_count, output spans_valid,
		output shortest_span, output longest_span, input ready
	);
	modport sink (
		input valid, input status, input held_count, input spans_valid,
		input shortest_span, input longest_span, output ready
	);
endinterface

/* hdl/bsst_cfg_if.sv */
interface bsst_cfg_if import bsst_pkg::*; ();
	logic valid;
	logic ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/bsst_mem.sv */
module bsst_mem import bsst_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/bsst_ctrl.sv */
module bsst_ctrl import bsst_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  item_t in_item,
	input  logic [CAP_W-1:0] capacity,
	output logic out_valid,
	input  logic out_ready,
	output result_t out_res,
	output logic mem_we,
	output logic [$clog2(MAX_ENTRIES)-1:0] mem_waddr,
	output logic [VAL_W-1:0] mem_wdata,
	output logic mem_re,
	output logic [$clog2(MAX_ENTRIES)-1:0] mem_raddr,
	input  logic [VAL_W-1:0] mem_rdata
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [VAL_W-1:0] val_q;
	logic rej_q;
	logic [VAL_W-1:0] min_q;
	logic [VAL_W-1:0] max_q;
	logic [VAL_W-1:0] gap_q;
	logic rd_v_s1;
	logic [VAL_W-1:0] gap_s2;
	logic gap_v_s2;
	logic out_valid_q;
	result_t res_q;

	logic accept;
	logic [VAL_W-1:0] biased;
	logic [CW-1:0] cnt_eff;
	logic [LW-1:0] cap_ext;
	logic [LW-1:0] max_ext;
	logic [LW-1:0] limit;
	logic full;
	logic [VAL_W-1:0] gap_new;
	logic pipe_empty;
	logic commit;
	logic load_out;
	logic spans_ok;
	logic [CW+CNT_W-1:0] cnt_wide;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign biased = {~in_item.new_value[VAL_W-1], in_item.new_value[VAL_W-2:0]};
	assign cnt_eff = in_item.start_new ? '0 : cnt_q;
	assign cap_ext = LW'(capacity);
	assign max_ext = LW'(MAX_ENTRIES);
	assign limit = (cap_ext < max_ext) ? cap_ext : max_ext;
	assign full = (LW'(cnt_eff) >= limit);

	assign mem_re = (state_q == ST_SCAN) && !rej_q && (idx_q < cnt_q);
	assign mem_raddr = idx_q[AW-1:0];
	assign gap_new = (val_q >= mem_rdata) ? (val_q - mem_rdata) : (mem_rdata - val_q);

	assign pipe_empty = !rd_v_s1 && !gap_v_s2;
	assign commit = (state_q == ST_DRAIN) && pipe_empty;
	assign mem_we = commit && !rej_q;
	assign mem_waddr = cnt_q[AW-1:0];
	assign mem_wdata = val_q;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign spans_ok = (cnt_q >= CW'(2));
	assign cnt_wide = {{CNT_W{1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			rej_q <= 1'b0;
			min_q <= '0;
			max_q <= '0;
			gap_q <= GAP_INIT;
			rd_v_s1 <= 1'b0;
			gap_v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
			gap_v_s2 <= rd_v_s1;
			if (gap_v_s2 && (gap_s2 < gap_q)) begin
				gap_q <= gap_s2;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rej_q <= full;
						idx_q <= '0;
						if (in_item.start_new) begin
							cnt_q <= '0;
							min_q <= '0;
							max_q <= '0;
							gap_q <= GAP_INIT;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						if (!rej_q) begin
							cnt_q <= cnt_q + CW'(1);
							if (cnt_q == '0) begin
								min_q <= val_q;
								max_q <= val_q;
							end else begin
								if (val_q < min_q) begin
									min_q <= val_q;
								end
								if (val_q > max_q) begin
									max_q <= val_q;
								end
							end
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= biased;
		end
		if (rd_v_s1) begin
			gap_s2 <= gap_new;
		end
		if (load_out) begin
			res_q.status <= rej_q;
			res_q.held_count <= cnt_wide[CNT_W-1:0];
			res_q.spans_valid <= spans_ok;
			res_q.shortest_span <= spans_ok ? gap_q : '0;
			res_q.longest_span <= spans_ok ? (max_q - min_q) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = res_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ENTRIES))
		else $error("held count above store depth");

	a_read_below_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (idx_q < cnt_q) && !rej_q)
		else $error("read beyond held entries");

	a_write_fits: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (LW'(cnt_q) < limit))
		else $error("write into a full set");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> pipe_empty)
		else $error("gap pipeline busy after commit");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("request taken while busy");
`endif

endmodule

/* hdl/bounded_set_span_tracker_unit.sv */
// A request is taken only while idle: the held values are scanned one entry per cycle
// through the single read port of the value store, the gap pipeline drains, the value
// is committed and the result is registered; an empty set or a rejected value skips the scan.
// No new request is accepted until the previous result has been loaded for output.
// Reset (arst_n low): the set is empty, capacity returns to 64, no result is pending.
module bounded_set_span_tracker_unit import bsst_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic clk,
	input  logic arst_n,
	bsst_in_if.sink item,
	bsst_out_if.source result,
	bsst_cfg_if.sink cfg
);

	localparam int AW = $clog2(MAX_ENTRIES);

	logic [CAP_W-1:0] capacity_q;
	item_t in_item;
	result_t out_res;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic mem_re;
	logic [AW-1:0] mem_raddr;
	logic [VAL_W-1:0] mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid) begin
			capacity_q <= cfg.data;
		end
	end

	assign in_item.new_value = item.new_value;
	assign in_item.start_new = item.start_new;

	bsst_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item.valid),
		.in_ready(item.ready),
		.in_item(in_item),
		.capacity(capacity_q),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.out_res(out_res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	bsst_mem #(
		.DEPTH(MAX_ENTRIES),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign result.status = out_res.status;
	assign result.held_count = out_res.held_count;
	assign result.spans_valid = out_res.spans_valid;
	assign result.shortest_span = out_res.shortest_span;
	assign result.longest_span = out_res.longest_span;

endmodule

/* dv/bounded_set_span_tracker_unit_test.sv */
`timescale 1ns / 1ps

module bounded_set_span_tracker_unit_test;
	import bsst_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;
	localparam logic signed [VAL_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

	logic clk;
	logic arst_n;

	bsst_in_if item();
	bsst_out_if result();
	bsst_cfg_if cfg();

	bounded_set_span_tracker_unit #(.MAX_ENTRIES(STORE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg(cfg)
	);

	logic [VAL_W-1:0] set_vals [STORE_DEPTH];
	int unsigned set_size = 0;
	logic [VAL_W-1:0] set_min = '0;
	logic [VAL_W-1:0] set_max = '0;
	logic [VAL_W-1:0] set_gap = GAP_INIT;
	logic [CAP_W-1:0] capacity_reg = CAP_RESET;

	result_t pending_spans [$];
	logic back_to_back = 1'b0;
	logic signed [VAL_W-1:0] cluster_base = '0;
	int unsigned failures = 0;
	int unsigned requests_sent = 0;
	int unsigned results_checked = 0;
	int unsigned rejects_seen = 0;
	int unsigned settings_used = 0;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic result_t predict_spans(input logic [VAL_W-1:0] raw, input logic restart);
		logic [VAL_W-1:0] biased;
		logic [VAL_W-1:0] d;
		int unsigned lim;
		result_t r;
		biased = raw ^ SIGN_FLIP;
		lim = capacity_reg < STORE_DEPTH ? capacity_reg : STORE_DEPTH;
		if (restart) begin
			set_size = 0;
			set_min = '0;
			set_max = '0;
			set_gap = GAP_INIT;
		end
		r.status = 1'b0;
		if (set_size >= lim) begin
			r.status = 1'b1;
		end else begin
			for (int i = 0; i < set_size; i++) begin
				d = biased > set_vals[i] ? biased - set_vals[i] : set_vals[i] - biased;
				if (d < set_gap)
					set_gap = d;
			end
			if (set_size == 0) begin
				set_min = biased;
				set_max = biased;
			end else begin
				if (biased < set_min)
					set_min = biased;
				if (biased > set_max)
					set_max = biased;
			end
			set_vals[set_size] = biased;
			set_size++;
		end
		r.held_count = CNT_W'(set_size);
		r.spans_valid = set_size >= 2;
		r.shortest_span = r.spans_valid ? set_gap : '0;
		r.longest_span = r.spans_valid ? set_max - set_min : '0;
		return r;
	endfunction

	task automatic offer_value(input logic signed [VAL_W-1:0] v, input logic restart);
		int unsigned gap;
		result_t predicted;
		gap = back_to_back ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.new_value <= v;
		item.start_new <= restart;
		do @(posedge clk); while (!item.ready);
		predicted = predict_spans(v, restart);
		pending_spans.insert(pending_spans.size(), predicted);
		requests_sent++;
	endtask

	task automatic wait_for_results();
		item.valid <= 1'b0;
		do @(posedge clk); while (pending_spans.size() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		wait_for_results();
		cfg.valid <= 1'b1;
		cfg.data <= c;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		capacity_reg = c;
		settings_used++;
	endtask

	initial begin
		int unsigned stall;
		result_t want;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = back_to_back ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			results_checked++;
			if (result.status)
				rejects_seen++;
			if (pending_spans.size() == 0) begin
				$error("result with no request pending");
				failures++;
			end else begin
				want = pending_spans.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					failures++;
				end
				if (result.held_count !== want.held_count) begin
					$error("held_count: expected %0d, got %0d",
						want.held_count, result.held_count);
					failures++;
				end
				if (result.spans_valid !== want.spans_valid) begin
					$error("spans_valid: expected %0d, got %0d",
						want.spans_valid, result.spans_valid);
					failures++;
				end
				if (result.shortest_span !== want.shortest_span) begin
					$error("shortest_span: expected %0h, got %0h",
						want.shortest_span, result.shortest_span);
					failures++;
				end
				if (result.longest_span !== want.longest_span) begin
					$error("longest_span: expected %0h, got %0h",
						want.longest_span, result.longest_span);
					failures++;
				end
			end
		end
	end

	task automatic test_span_extremes();
		offer_value(MOST_NEGATIVE, 1'b1);
		offer_value(MOST_POSITIVE, 1'b0);
		offer_value('0, 1'b0);
		offer_value('1, 1'b0);
		offer_value('1, 1'b0);
		offer_value(MOST_POSITIVE, 1'b1);
		offer_value(MOST_POSITIVE, 1'b0);
	endtask

	task automatic test_capacity_edges();
		write_capacity('0);
		offer_value(32'sd5, 1'b0);
		offer_value(-32'sd5, 1'b1);
		write_capacity(7'd1);
		offer_value(32'sd7, 1'b1);
		offer_value(32'sd8, 1'b0);
		offer_value(32'sd9, 1'b1);
		write_capacity(7'd2);
		offer_value(-32'sd3, 1'b0);
		offer_value(32'sd4, 1'b0);
		offer_value(32'sd4, 1'b1);
	endtask

	task automatic test_saturated_limit();
		write_capacity('1);
		for (int n = 0; n < STORE_DEPTH + 2; n++)
			offer_value($urandom, n == 0);
		write_capacity(7'd65);
		offer_value(32'sd1, 1'b0);
		offer_value(-32'sd1, 1'b1);
		for (int n = 0; n < STORE_DEPTH + 1; n++)
			offer_value($urandom, 1'b0);
	endtask

	task automatic test_random_sets();
		int unsigned sent;
		int unsigned phase_len;
		int unsigned lim;
		int unsigned pick;
		logic [CAP_W-1:0] cap;
		logic signed [VAL_W-1:0] v;
		logic restart;
		sent = 0;
		for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
			case (phase % 6)
				0: cap = CAP_RESET;
				1: cap = '0;
				2: cap = '1;
				default: cap = CAP_W'($urandom_range(1, 12));
			endcase
			write_capacity(cap);
			back_to_back = $urandom_range(0, 3) == 0;
			lim = cap < STORE_DEPTH ? cap : STORE_DEPTH;
			phase_len = cap == 0 ? 20 : $urandom_range(100, 200);
			for (int n = 0; n < phase_len; n++) begin
				restart = $urandom_range(0, lim + 3) == 0;
				if (restart)
					cluster_base = $urandom;
				pick = $urandom_range(0, 9);
				if (pick < 5) begin
					v = $urandom;
				end else if (pick < 8) begin
					v = cluster_base + $signed($urandom_range(0, 31)) - 16;
				end else if (pick == 8) begin
					case ($urandom_range(0, 3))
						0: v = MOST_NEGATIVE;
						1: v = MOST_POSITIVE;
						2: v = '0;
						default: v = '1;
					endcase
				end else begin
					v = cluster_base;
				end
				offer_value(v, restart);
				// hold the sender until every result is back
				if (phase == 3 && n == phase_len / 2)
					wait_for_results();
			end
			sent += phase_len;
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		item.valid <= 1'b0;
		item.new_value <= '0;
		item.start_new <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_span_extremes();
		test_capacity_edges();
		test_saturated_limit();
		test_random_sets();
		wait_for_results();
		repeat (80) @(posedge clk);
		$display("summary: %0d requests, %0d results checked, %0d rejected as full",
			requests_sent, results_checked, rejects_seen);
		$display("summary: %0d capacity settings, %0d mismatches", settings_used, failures);
		if (failures == 0 && pending_spans.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
